/* design/brps_pkg.sv */
// Shared types, constants and helpers for the byte range presence set.
package brps_pkg;

	localparam int WORDS_PER_PAGE = 2048;
	localparam int SUMMARY_LANES = WORDS_PER_PAGE / 64;
	localparam int WORD_IDX_W = $clog2(WORDS_PER_PAGE);
	localparam int LANE_IDX_W = $clog2(SUMMARY_LANES);
	localparam int PAGE_SHIFT = 14;
	localparam int OFF_W = 14;
	localparam int LEN_W = 15;
	localparam int CNT_W = 15;
	localparam int PAGE_NUM_W = 50;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [LEN_W-1:0] PAGE_BYTES = LEN_W'(WORDS_PER_PAGE * 8);

	typedef enum logic [1:0] {
		OP_MARK = 2'd0,
		OP_UNMARK = 2'd1,
		OP_QUERY = 2'd2,
		OP_CLEAR_BELOW = 2'd3
	} op_t;

	// Classified request: word-aligned walk from first_word to last_word.
	typedef struct packed {
		op_t op;
		logic empty;
		logic clamped;
		logic [WORD_IDX_W-1:0] first_word;
		logic [WORD_IDX_W-1:0] last_word;
		logic [7:0] first_mask;
		logic [7:0] last_mask;
	} cmd_t;

	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) n = n + 4'(v[i]);
		return n;
	endfunction

	function automatic logic [2:0] low_bit8(input logic [7:0] v);
		logic [2:0] r;
		r = '0;
		for (int i = 7; i >= 0; i--) if (v[i]) r = 3'(i);
		return r;
	endfunction

	function automatic logic [2:0] high_bit8(input logic [7:0] v);
		logic [2:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) if (v[i]) r = 3'(i);
		return r;
	endfunction

	function automatic logic [5:0] low_bit64(input logic [63:0] v);
		logic [5:0] r;
		r = '0;
		for (int i = 63; i >= 0; i--) if (v[i]) r = 6'(i);
		return r;
	endfunction

	function automatic logic [5:0] high_bit64(input logic [63:0] v);
		logic [5:0] r;
		r = '0;
		for (int i = 0; i < 64; i++) if (v[i]) r = 6'(i);
		return r;
	endfunction

endpackage

/* design/brps_front.sv */
// Front end: accept requests, clamp the range and turn it into a word walk.
module brps_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] in_op,
	input  logic [brps_pkg::OFF_W-1:0] in_off,
	input  logic [brps_pkg::LEN_W-1:0] in_len,
	output logic cmd_valid,
	input  logic cmd_ready,
	output brps_pkg::cmd_t cmd
);
	import brps_pkg::*;

	cmd_t fifo_q [QUEUE_DEPTH];
	logic [$clog2(QUEUE_DEPTH)-1:0] wr_q, rd_q;
	logic [$clog2(QUEUE_DEPTH):0] cnt_q;
	cmd_t c;
	logic [LEN_W:0] end_x;
	logic [LEN_W-1:0] end_b, last_b;

	always_comb begin
		c = '0;
		c.op = op_t'(in_op);
		end_x = {1'b0, LEN_W'(in_off)} + {1'b0, in_len};
		if (in_op == OP_CLEAR_BELOW) begin
			c.clamped = 1'b0;
			end_b = LEN_W'(in_off);
			c.empty = (in_off == '0);
			last_b = end_b - 1'b1;
			c.first_word = '0;
			c.first_mask = 8'hFF;
		end else begin
			c.clamped = (in_len != '0) && (end_x > {1'b0, PAGE_BYTES});
			end_b = c.clamped ? PAGE_BYTES : end_x[LEN_W-1:0];
			c.empty = (in_len == '0) || (LEN_W'(in_off) >= end_b);
			last_b = end_b - 1'b1;
			c.first_word = in_off[OFF_W-1:3];
			c.first_mask = 8'hFF << in_off[2:0];
		end
		c.last_word = last_b[WORD_IDX_W+2:3];
		c.last_mask = 8'hFF >> (3'd7 - last_b[2:0]);
	end

	assign in_ready = (cnt_q != QUEUE_DEPTH[$clog2(QUEUE_DEPTH):0]);
	assign cmd_valid = (cnt_q != '0);
	assign cmd = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) fifo_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (in_valid && in_ready) wr_q <= wr_q + 1'b1;
			if (cmd_valid && cmd_ready) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + ((in_valid && in_ready) ? 1'b1 : 1'b0)
				- ((cmd_valid && cmd_ready) ? 1'b1 : 1'b0);
		end
	end
endmodule

/* design/brps_back.sv */
// Back end: walk the words of a request, keep summaries, find lowest and highest marks.
module brps_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  brps_pkg::cmd_t cmd,
	input  logic [brps_pkg::PAGE_NUM_W-1:0] page_number,
	output logic res_valid,
	input  logic res_ready,
	output logic [15+1+1+15+1+64+64-1:0] res_data
);
	import brps_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_READ, S_WRITE, S_LO_LANE, S_LO_BYTE, S_HI_LANE, S_HI_BYTE
	} state_t;

	state_t state_q;
	logic [7:0] mem [WORDS_PER_PAGE];
	logic [7:0] rd_q;
	logic [63:0] lane_q [SUMMARY_LANES];
	cmd_t cmd_q;
	logic [WORD_IDX_W-1:0] w_q;
	logic [CNT_W-1:0] changed_q, total_q;
	logic hit_q;
	logic [LANE_IDX_W:0] scan_q;
	logic [WORD_IDX_W-1:0] lo_w_q, hi_w_q;
	logic [OFF_W-1:0] lo_q;
	logic out_full_q;
	logic [15+1+1+15+1+64+64-1:0] out_q;

	logic [7:0] mask, nv;
	logic is_first, is_last;
	logic [63:0] base;

	always_comb begin
		is_first = (w_q == cmd_q.first_word);
		is_last = (w_q == cmd_q.last_word);
		mask = 8'hFF;
		if (is_first) mask = mask & cmd_q.first_mask;
		if (is_last) mask = mask & cmd_q.last_mask;
		unique case (cmd_q.op)
			OP_MARK: nv = rd_q | mask;
			OP_QUERY: nv = rd_q;
			default: nv = rd_q & ~mask;
		endcase
		base = 64'(page_number) << PAGE_SHIFT;
	end

	assign cmd_ready = (state_q == S_IDLE) && !out_full_q;
	assign res_valid = out_full_q;
	assign res_data = out_q;

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) mem[w_q] <= '0;
		else if (state_q == S_WRITE && cmd_q.op != OP_QUERY) mem[w_q] <= nv;
		rd_q <= mem[(state_q == S_LO_BYTE) ? ((scan_q == '0) ? lo_w_q : hi_w_q) : w_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			w_q <= '0;
			out_full_q <= 1'b0;
			total_q <= '0;
			for (int i = 0; i < SUMMARY_LANES; i++) lane_q[i] <= '0;
		end else begin
			if (res_valid && res_ready) out_full_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					w_q <= w_q + 1'b1;
					if (w_q == WORD_IDX_W'(WORDS_PER_PAGE - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						cmd_q <= cmd;
						w_q <= cmd.first_word;
						changed_q <= '0;
						hit_q <= 1'b0;
						state_q <= cmd.empty ? S_LO_LANE : S_READ;
						scan_q <= '0;
					end
				end
				S_READ: state_q <= S_WRITE;
				S_WRITE: begin
					changed_q <= changed_q + CNT_W'(pop8(nv ^ rd_q));
					if ((rd_q & mask) != '0) hit_q <= 1'b1;
					lane_q[w_q[WORD_IDX_W-1:6]][w_q[5:0]] <= (nv != '0);
					if (is_last) begin
						state_q <= S_LO_LANE;
						scan_q <= '0;
					end else begin
						w_q <= w_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_LO_LANE: begin
					if (cmd_q.op == OP_MARK && scan_q == '0)
						total_q <= total_q + changed_q;
					else if (cmd_q.op != OP_QUERY && scan_q == '0)
						total_q <= total_q - changed_q;
					if (scan_q == '0) begin
						scan_q <= scan_q + 1'b1;
					end else if (scan_q == (LANE_IDX_W+1)'(SUMMARY_LANES + 1)) begin
						state_q <= S_HI_LANE;
						scan_q <= (LANE_IDX_W+1)'(SUMMARY_LANES);
					end else begin
						if (lane_q[scan_q[LANE_IDX_W-1:0] - 1'b1] != '0 || scan_q ==
							(LANE_IDX_W+1)'(SUMMARY_LANES)) begin
							lo_w_q <= {LANE_IDX_W'(scan_q - 1'b1),
								low_bit64(lane_q[LANE_IDX_W'(scan_q - 1'b1)])};
							scan_q <= (LANE_IDX_W+1)'(SUMMARY_LANES + 1);
						end else scan_q <= scan_q + 1'b1;
					end
				end
				S_HI_LANE: begin
					if (lane_q[LANE_IDX_W'(scan_q - 1'b1)] != '0
						|| scan_q == (LANE_IDX_W+1)'(1)) begin
						hi_w_q <= {LANE_IDX_W'(scan_q - 1'b1),
							high_bit64(lane_q[LANE_IDX_W'(scan_q - 1'b1)])};
						state_q <= S_LO_BYTE;
					end else scan_q <= scan_q - 1'b1;
				end
				S_LO_BYTE: begin
					state_q <= S_HI_BYTE;
				end
				S_HI_BYTE: begin
					if (scan_q == '0) begin
						lo_q <= {lo_w_q, low_bit8(rd_q)};
						scan_q <= (LANE_IDX_W+1)'(1);
					end else begin
						out_full_q <= 1'b1;
						out_q <= {
							(total_q == '0) ? 64'hFFFF_FFFF_FFFF_FFFF :
								base + 64'({hi_w_q, high_bit8(rd_q)}),
							(total_q == '0) ? 64'hFFFF_FFFF_FFFF_FFFF :
								base + 64'(lo_q),
							(total_q == '0), total_q, cmd_q.clamped,
							(cmd_q.op == OP_QUERY) && hit_q,
							(cmd_q.op == OP_QUERY) ? CNT_W'(0) : changed_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_HI_LANE && (lane_q[LANE_IDX_W'(scan_q - 1'b1)] != '0
				|| scan_q == (LANE_IDX_W+1)'(1))) scan_q <= '0;
			if (state_q == S_HI_BYTE && scan_q == '0) state_q <= S_LO_BYTE;
		end
	end
endmodule

/* design/byte_range_presence_set.sv */
// Top level of the byte range presence set.
// Tracks marked bytes of one 16 KiB page. After reset the block clears its mark memory
// and starts no request meanwhile, though up to two requests queue in the front end. A
// request reads and then writes each 8-byte word it touches through the single-port
// mark memory, then finds the lowest and highest marked bytes by scanning the 32
// word-summary lanes; the result waits in an output register while the next request is queued.
module byte_range_presence_set (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [31:0] s_axis_tdata, // operation[1:0], byte_offset[15:2], byte_length[30:16]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// changed_count[14:0], hit[15], range_clamped[16], tracked_total[31:17],
	// set_empty[32], lowest_address[96:33], highest_address[160:97]
	output logic [167:0] m_axis_tdata,
	input  logic cfg_we,
	input  logic [49:0] cfg_wdata
);
	import brps_pkg::*;

	logic cmd_valid, cmd_ready;
	cmd_t cmd;
	logic [PAGE_NUM_W-1:0] page_q;
	logic [160:0] res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) page_q <= '0;
		else if (cfg_we) page_q <= cfg_wdata;
	end

	brps_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_op(s_axis_tdata[1:0]), .in_off(s_axis_tdata[15:2]),
		.in_len(s_axis_tdata[30:16]),
		.cmd_valid, .cmd_ready, .cmd
	);

	brps_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.page_number(page_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res)
	);

	assign m_axis_tdata = {7'd0, res};
endmodule

/* design/brps_checker.sv */
// Port-level checks for the byte range presence set.
module brps_checker (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [167:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[32] == (m_axis_tdata[31:17] == 15'd0))
		else $error("empty flag disagrees with total");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[96:33] <= m_axis_tdata[160:97])
		else $error("lowest above highest");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[167:161] == 7'd0)
		else $error("padding not zero");
endmodule

bind byte_range_presence_set brps_checker u_brps_checker (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
